### rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante, skipped while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante, also across reset.
`define ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dec_pkg.sv
package dec_pkg;

  localparam int WORD_W       = 64;
  localparam int WORD_BITS_DEF = 64;
  localparam int MAX_WORDS_DEF = 16;
  localparam int QUEUE_DEPTH  = 2;
  localparam int POS_W        = 4;
  localparam int CNT_W        = 7;
  localparam int BIT_W        = 6;
  localparam int IDX_W        = 11;
  localparam int IN_DATA_W    = 2 * WORD_W;
  localparam int OUT_FIELDS_W = 6 * IDX_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [CNT_W-1:0] hole_cnt;
    logic [CNT_W-1:0] part_cnt;
    logic [IDX_W-1:0] hole_lo;
    logic [IDX_W-1:0] hole_hi;
    logic [IDX_W-1:0] part_lo;
    logic [IDX_W-1:0] part_hi;
    logic             last;
  } dec_entry_t;

  typedef struct packed {
    logic             count_mismatch;
    logic [IDX_W-1:0] particle_second;
    logic [IDX_W-1:0] particle_first;
    logic [IDX_W-1:0] hole_second;
    logic [IDX_W-1:0] hole_first;
    logic [IDX_W-1:0] particle_count;
    logic [IDX_W-1:0] excitation_degree;
  } dec_result_t;

endpackage

### rtl/dec_front.sv
module dec_front #(
  parameter int WORD_BITS = dec_pkg::WORD_BITS_DEF,
  parameter int MAX_WORDS = dec_pkg::MAX_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [dec_pkg::WORD_W-1:0]   word_a,
  input  logic [dec_pkg::WORD_W-1:0]   word_b,
  input  logic                         last_word,
  input  logic                         push_ready,
  output logic                         push_valid,
  output dec_pkg::dec_entry_t          entry
);
  import dec_pkg::*;

  localparam logic [WORD_W-1:0] WORD_MASK = {WORD_W{1'b1}} >> (WORD_W - WORD_BITS);

  function automatic logic [CNT_W-1:0] pop_count(input logic [WORD_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] k;
    k = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) k = BIT_W'(i);
    end
    return k;
  endfunction

  logic [POS_W-1:0]  pos;
  logic [WORD_W-1:0] holes, parts, holes_rest, parts_rest;
  logic [IDX_W-1:0]  pos_base;
  logic              last_eff;

  assign holes      = word_a & ~word_b & WORD_MASK;
  assign parts      = word_b & ~word_a & WORD_MASK;
  assign holes_rest = holes & (holes - WORD_W'(1));
  assign parts_rest = parts & (parts - WORD_W'(1));
  assign pos_base   = IDX_W'(pos) * IDX_W'(WORD_BITS);
  assign last_eff   = last_word || (pos == POS_W'(MAX_WORDS - 1));

  always_comb begin
    entry.hole_cnt = pop_count(holes);
    entry.part_cnt = pop_count(parts);
    entry.hole_lo  = pos_base + IDX_W'(lowest_bit(holes));
    entry.hole_hi  = pos_base + IDX_W'(lowest_bit(holes_rest));
    entry.part_lo  = pos_base + IDX_W'(lowest_bit(parts));
    entry.part_hi  = pos_base + IDX_W'(lowest_bit(parts_rest));
    entry.last     = last_eff;
  end

  assign push_valid = in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (in_valid && push_ready) begin
      pos <= last_eff ? '0 : pos + POS_W'(1);
    end
  end

endmodule

### rtl/dec_queue.sv
module dec_queue #(
  parameter int DEPTH = dec_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  dec_pkg::dec_entry_t push_entry,
  output logic                pop_valid,
  input  logic                pop_ready,
  output dec_pkg::dec_entry_t pop_entry
);
  import dec_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  dec_entry_t        slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_QW-1:0] count;
  logic              push, pop;

  assign push_ready = count != CNT_QW'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_QW'(1);
      else if (pop && !push) count <= count - CNT_QW'(1);
    end
  end

endmodule

### rtl/dec_back.sv
module dec_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  dec_pkg::dec_entry_t  q_entry,
  output logic                 res_valid,
  input  logic                 res_ready,
  output dec_pkg::dec_result_t result
);
  import dec_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } slots_t;

  function automatic slots_t take_slots(input logic [IDX_W-1:0] total,
                                        input logic [CNT_W-1:0] cnt,
                                        input slots_t cur, input slots_t fresh);
    slots_t s;
    s = cur;
    if (total == '0) begin
      if (cnt != '0) s.lo = fresh.lo;
      if (cnt > CNT_W'(1)) s.hi = fresh.hi;
    end else if (total == IDX_W'(1)) begin
      if (cnt != '0) s.hi = fresh.lo;
    end
    return s;
  endfunction

  function automatic logic [IDX_W-1:0] slot_out(input logic [IDX_W-1:0] total,
                                                input logic [IDX_W-1:0] need,
                                                input logic [IDX_W-1:0] raw,
                                                input logic base);
    return (total < need) ? '0 : raw + IDX_W'(base);
  endfunction

  logic             index_base;
  logic [IDX_W-1:0] hole_total, particle_total, hole_total_next, particle_total_next;
  slots_t           hole_slots, part_slots, hole_slots_next, part_slots_next;
  logic             pop;

  assign q_ready = !q_entry.last || !res_valid || res_ready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    hole_total_next     = hole_total + IDX_W'(q_entry.hole_cnt);
    particle_total_next = particle_total + IDX_W'(q_entry.part_cnt);
    hole_slots_next = take_slots(hole_total, q_entry.hole_cnt, hole_slots,
                                 '{lo: q_entry.hole_lo, hi: q_entry.hole_hi});
    part_slots_next = take_slots(particle_total, q_entry.part_cnt, part_slots,
                                 '{lo: q_entry.part_lo, hi: q_entry.part_hi});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_base <= 1'b1;
    end else if (cfg_wr_en) begin
      index_base <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hole_total     <= '0;
      particle_total <= '0;
      hole_slots     <= '0;
      part_slots     <= '0;
    end else if (pop) begin
      if (q_entry.last) begin
        hole_total     <= '0;
        particle_total <= '0;
        hole_slots     <= '0;
        part_slots     <= '0;
      end else begin
        hole_total     <= hole_total_next;
        particle_total <= particle_total_next;
        hole_slots     <= hole_slots_next;
        part_slots     <= part_slots_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && q_entry.last) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_entry.last) begin
      result.excitation_degree <= hole_total_next;
      result.particle_count    <= particle_total_next;
      result.hole_first      <= slot_out(hole_total_next, IDX_W'(1), hole_slots_next.lo,
                                         index_base);
      result.hole_second     <= slot_out(hole_total_next, IDX_W'(2), hole_slots_next.hi,
                                         index_base);
      result.particle_first  <= slot_out(particle_total_next, IDX_W'(1), part_slots_next.lo,
                                         index_base);
      result.particle_second <= slot_out(particle_total_next, IDX_W'(2), part_slots_next.hi,
                                         index_base);
      result.count_mismatch  <= hole_total_next != particle_total_next;
    end
  end

endmodule

### rtl/determinant_excitation_compare.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: word_a, word_b; s_tlast: last_word
// m_       out  m_tvalid/m_tready  m_tdata: result fields of one determinant pair
// cfg_     in   cfg_wr_en          cfg_wr_data: orbital_index_base
// One word pair per cycle is accepted while the queue has room; the front counts and
// encodes holes and particles in the accept cycle; the back folds them from the queue.
// A result enters the output register when its last word leaves the queue and holds.
// The two-entry queue and the output register keep input flowing while m_tready is low,
// until both fill. Synchronous reset clears counts, slots and the index base (to 1).
module determinant_excitation_compare #(
  parameter int WORD_BITS   = dec_pkg::WORD_BITS_DEF,
  parameter int MAX_WORDS   = dec_pkg::MAX_WORDS_DEF,
  parameter int QUEUE_DEPTH = dec_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [dec_pkg::IN_DATA_W-1:0]    s_tdata,   // word_a, word_b
  input  logic                             s_tlast,   // last_word
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // excitation_degree, particle_count, hole_first, hole_second, particle_first,
  // particle_second, count_mismatch, zero fill
  output logic [dec_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data
);
  import dec_pkg::*;
  `include "assert_macros.svh"

  logic        push_valid, push_ready, q_valid, q_ready;
  dec_entry_t  push_entry, q_entry;
  dec_result_t result;

  dec_front #(
    .WORD_BITS(WORD_BITS),
    .MAX_WORDS(MAX_WORDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .word_a    (s_tdata[WORD_W-1:0]),
    .word_b    (s_tdata[IN_DATA_W-1:WORD_W]),
    .last_word (s_tlast),
    .push_ready(push_ready),
    .push_valid(push_valid),
    .entry     (push_entry)
  );

  dec_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_entry(push_entry),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_entry (q_entry)
  );

  dec_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_entry    (q_entry),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .result     (result)
  );

  assign s_tready = push_ready;
  assign m_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0), result};

  `ASSERT_NEXT(a_reset_no_result, clk, rst, !m_tvalid, "result valid right after reset")
  `ASSERT_IMPLIES(a_mismatch_flag, clk, rst, m_tvalid,
    result.count_mismatch == (result.excitation_degree != result.particle_count),
    "mismatch flag disagrees with hole and particle counts")
  `ASSERT_IMPLIES(a_hole_slots, clk, rst, m_tvalid && result.excitation_degree == '0,
    result.hole_first == '0 && result.hole_second == '0, "hole slot set without holes")
  `ASSERT_IMPLIES(a_part_slots, clk, rst,
    m_tvalid && (result.particle_count == '0 || result.particle_count == IDX_W'(1)),
    result.particle_second == '0, "second particle slot set with fewer than two")

endmodule

### tb/determinant_excitation_compare_tb.sv
`timescale 1ns / 100ps

module determinant_excitation_compare_tb;
  import dec_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 6;
  localparam logic [63:0] ALL_ONES = '1;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wr_en;
  logic                  cfg_wr_data;

  determinant_excitation_compare dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // running excitation state of the open determinant pair
  logic [3:0]  run_pos;
  logic [10:0] run_holes;
  logic [10:0] run_parts;
  logic [10:0] hole_lo;
  logic [10:0] hole_hi;
  logic [10:0] part_lo;
  logic [10:0] part_hi;
  logic [11:0] run_diff;
  logic        index_base;

  dec_result_t pending_results[$];
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          src_idle_pct = 14;
  int          sink_idle_pct = 14;
  int          sink_hold_len = 0;
  int          stall_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_pair_state();
    run_pos   = '0;
    run_holes = '0;
    run_parts = '0;
    hole_lo   = '0;
    hole_hi   = '0;
    part_lo   = '0;
    part_hi   = '0;
    run_diff  = '0;
  endfunction

  function automatic void take_lowest(input logic [63:0] m, input logic [10:0] total,
                                      inout logic [10:0] lo, inout logic [10:0] hi);
    logic [10:0] taken;
    taken = total;
    for (int i = 0; i < 64; i++) begin
      if (m[i] && taken < 2) begin
        if (taken == 0) lo = {1'b0, run_pos, 6'(i)};
        else hi = {1'b0, run_pos, 6'(i)};
        taken++;
      end
    end
  endfunction

  function automatic logic [10:0] slot_value(logic [10:0] total, int need, logic [10:0] raw);
    if (total < need) return '0;
    return raw + 11'(index_base);
  endfunction

  function automatic void fold_word_pair(logic [63:0] a, logic [63:0] b, logic last);
    logic [63:0] holes;
    logic [63:0] parts;
    logic [10:0] nh;
    logic [10:0] np;
    logic        done;
    dec_result_t res;
    holes = a & ~b;
    parts = b & ~a;
    nh = 11'($countones(holes));
    np = 11'($countones(parts));
    take_lowest(holes, run_holes, hole_lo, hole_hi);
    take_lowest(parts, run_parts, part_lo, part_hi);
    run_holes = run_holes + nh;
    run_parts = run_parts + np;
    run_diff  = run_diff + 12'(nh) - 12'(np);
    done = last || (run_pos == 4'd15);
    if (!done) begin
      run_pos = run_pos + 4'd1;
    end else begin
      res.excitation_degree = run_holes;
      res.particle_count    = run_parts;
      res.hole_first        = slot_value(run_holes, 1, hole_lo);
      res.hole_second       = slot_value(run_holes, 2, hole_hi);
      res.particle_first    = slot_value(run_parts, 1, part_lo);
      res.particle_second   = slot_value(run_parts, 2, part_hi);
      res.count_mismatch    = (run_diff != 0);
      pending_results.push_back(res);
      clear_pair_state();
    end
  endfunction

  function automatic void check_field(string name, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    dec_result_t got;
    dec_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = dec_result_t'(m_tdata[OUT_FIELDS_W-1:0]);
      if (pending_results.size() == 0) begin
        $error("unexpected result item: tdata %h", m_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("excitation_degree", want.excitation_degree, got.excitation_degree);
        check_field("particle_count", want.particle_count, got.particle_count);
        check_field("hole_first", want.hole_first, got.hole_first);
        check_field("hole_second", want.hole_second, got.hole_second);
        check_field("particle_first", want.particle_first, got.particle_first);
        check_field("particle_second", want.particle_second, got.particle_second);
        check_field("count_mismatch", 11'(want.count_mismatch), 11'(got.count_mismatch));
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_len > 0) begin
        hold_left = sink_hold_len;
        sink_hold_len = 0;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_word(logic [63:0] a, logic [63:0] b, logic last);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    fold_word_pair(a, b, last);
    words_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_index_base(logic value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    index_base = value;
  endtask

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed_edges();
    send_word('0, '0, 1'b1);
    send_word(ALL_ONES, '0, 1'b1);
    send_word('0, ALL_ONES, 1'b1);
    send_word(64'h1, 64'h8000_0000_0000_0000, 1'b1);
    // holes and particles spread over three words
    send_word(64'h10, 64'h0, 1'b0);
    send_word(64'h0, 64'h3, 1'b0);
    send_word(64'h8000_0000_0000_0000, 64'h4000_0000_0000_0000, 1'b1);
    // never marked last: the sixteenth word closes the pair
    for (int w = 0; w < 16; w++) send_word(ALL_ONES, '0, 1'b0);
  endtask

  task automatic test_index_base();
    set_index_base(1'b0);
    send_word(64'h1, 64'h2, 1'b1);
    send_word(64'h5, 64'ha, 1'b1);
    send_word(64'h0, 64'h0, 1'b0);
    send_word(64'h0, 64'h1, 1'b1);
  endtask

  task automatic send_random_pair();
    int          len;
    int          pick;
    int          flips;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] flip_mask;
    pick = $urandom_range(99);
    if (pick < 65) len = $urandom_range(1, 3);
    else if (pick < 85) len = $urandom_range(4, 8);
    else if (pick < 95) len = $urandom_range(9, 16);
    else len = $urandom_range(17, 24);
    for (int w = 0; w < len; w++) begin
      pick = $urandom_range(99);
      a = random_word();
      if (pick < 60) begin
        flip_mask = '0;
        flips = $urandom_range(0, 4);
        for (int k = 0; k < flips; k++) flip_mask[$urandom_range(63)] = 1'b1;
        b = a ^ flip_mask;
      end else if (pick < 75) begin
        b = random_word();
      end else if (pick < 82) begin
        b = '0;
      end else if (pick < 89) begin
        b = a;
        a = '0;
      end else if (pick < 94) begin
        a = ALL_ONES;
        b = random_word();
      end else begin
        b = a;
      end
      send_word(a, b, w == len - 1);
    end
  endtask

  task automatic test_random_pairs(int target);
    while (words_sent < target) send_random_pair();
  endtask

  task automatic test_backpressure();
    drain_results();
    sink_hold_len = 120;
    for (int n = 0; n < 30; n++) send_word(random_word(), random_word(), 1'b1);
  endtask

  initial begin
    rst         <= 1'b1;
    s_tvalid    <= 1'b0;
    s_tdata     <= '0;
    s_tlast     <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    index_base = 1'b1;
    clear_pair_state();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edges();
    test_index_base();
    test_random_pairs(250);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_random_pairs(350);
    src_idle_pct  = 14;
    sink_idle_pct = 14;
    set_index_base(1'b1);
    test_random_pairs(520);
    test_backpressure();
    drain_results();

    if (mismatch_count == 0 && pending_results.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
